// ===== hw/rtl/rsmp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package rsmp_pkg;
   localparam int TAPS       = 32;
   localparam int TAP_W      = $clog2(TAPS);
   localparam int HALF       = TAPS / 2;
   localparam int PHASES     = 512;
   localparam int PHASE_W    = $clog2(PHASES);
   localparam int RING_DEPTH = 64;
   localparam int RING_W     = $clog2(RING_DEPTH);
   localparam int COEF_COUNT = (PHASES + 1) * TAPS;
   localparam int COEF_AW    = 15;
   localparam int MAX_OUT    = 16;
   localparam int QDEPTH     = 4;
   localparam int QPTR_W     = $clog2(QDEPTH);

   localparam logic [1:0] ACT_SAMPLE  = 2'd0;
   localparam logic [1:0] ACT_SILENCE = 2'd1;
   localparam logic [1:0] ACT_COEF    = 2'd2;

   typedef struct packed {
      logic [1:0]          action;
      logic signed [23:0]  sample_ch0;
      logic signed [23:0]  sample_ch1;
      logic [COEF_AW-1:0]  coef_index;
      logic signed [17:0]  coef_value;
   } item_type;
endpackage
`default_nettype wire

// ===== hw/rtl/rsmp_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rsmp_front import rsmp_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   output logic          in_ready,
   input  wire item_type in_item,
   output logic          q_valid,
   output item_type      q_item,
   input  wire logic     q_pop
);
   item_type           mem_ff [QDEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]    count_ff, count_in;
   logic               push, pop;

   assign in_ready = (count_ff != QDEPTH[QPTR_W:0]);
   assign q_valid  = (count_ff != '0);
   assign q_item   = mem_ff[rd_ptr_ff];
   assign push     = in_valid && in_ready;
   assign pop      = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_item;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end
endmodule
`default_nettype wire

// ===== hw/rtl/rsmp_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rsmp_core import rsmp_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [28:0] csr_wr_data,
   input  wire logic        q_valid,
   input  wire item_type    q_item,
   output logic             q_pop,
   output logic             out_valid,
   input  wire logic        out_ready,
   output logic [23:0]      out_ch0,
   output logic [23:0]      out_ch1,
   output logic             out_last
);
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CHECK = 2'd1;
   localparam logic [1:0] ST_RUN   = 2'd2;

   function automatic logic [23:0] round_sat(input logic signed [47:0] acc);
      logic signed [47:0] r;
      r = (acc + 48'sd65536) >>> 17;
      if (r > 48'sd8388607) begin
         return 24'h7fffff;
      end else if (r < -48'sd8388608) begin
         return 24'h800000;
      end
      return r[23:0];
   endfunction

   logic [28:0]  step_ff;
   logic [39:0]  pos_ff, pos_in;
   logic [15:0]  fw_ff, fw_in, oldest_ff, oldest_in;
   logic [1:0]   state_ff, state_in;
   logic [4:0]   cnt_ff, cnt_in;
   logic         have_ff, have_in;
   logic [TAP_W:0] tap_ff, tap_in;
   logic         v1_ff, v1_in, v2_ff, v3_ff;
   logic [23:0]  res0_ff, res1_ff;
   logic         oval_ff, oval_in, olast_ff, olast_in;
   logic [23:0]  och0_ff, och0_in, och1_ff, och1_in;
   logic signed [47:0] acc0_ff, acc0_in, acc1_ff, acc1_in;

   logic [47:0]  ring_mem [RING_DEPTH];
   logic [RING_DEPTH-1:0] ring_vld_ff;
   logic [47:0]  ring_rd_ff;
   logic         ring_rd_vld_ff;
   logic signed [17:0] coef_mem [COEF_COUNT];
   logic signed [17:0] lo_rd_ff, hi_rd_ff;

   logic signed [43:0] prod_ff;
   logic signed [17:0] lo_d_ff;
   logic signed [23:0] s0_d_ff, s1_d_ff;
   logic signed [41:0] m0_ff, m1_ff;

   logic [15:0]  base, first, fw_diff, old_diff, live, nb, cand, cand_diff;
   logic         go, out_free, full, ring_we, coef_we, issue, done;
   logic [TAP_W-1:0] t;
   logic [PHASE_W-1:0] row;
   logic [COEF_AW-1:0] lo_addr, hi_addr;
   logic [RING_W-1:0]  slot;
   logic signed [18:0] diff;
   logic signed [24:0] wsig;
   logic signed [43:0] blend;
   logic signed [17:0] coef;
   logic [39:0]  pos_next;

   assign base     = pos_ff[39:24];
   assign first    = base - 16'(HALF - 1);
   assign fw_diff  = fw_ff - (base + 16'(HALF + 1));
   assign old_diff = first - oldest_ff;
   assign go       = (cnt_ff < 5'(MAX_OUT)) && !fw_diff[15] && !old_diff[15];
   assign live     = fw_ff - oldest_ff;
   assign full     = !live[15] && (live >= 16'(RING_DEPTH));
   assign out_free = !oval_ff || out_ready;
   assign q_pop    = (state_ff == ST_IDLE) && q_valid;
   assign ring_we  = q_pop && (q_item.action == ACT_SAMPLE || q_item.action == ACT_SILENCE)
                     && !full;
   assign coef_we  = q_pop && (q_item.action == ACT_COEF)
                     && (q_item.coef_index < COEF_AW'(COEF_COUNT));

   assign t        = tap_ff[TAP_W-1:0];
   assign row      = pos_ff[23:24-PHASE_W];
   assign lo_addr  = COEF_AW'({row, t});
   assign hi_addr  = COEF_AW'({({1'b0, row} + 1'b1), t});
   assign slot     = first[RING_W-1:0] + RING_W'(t);
   assign issue    = (state_ff == ST_RUN) && !tap_ff[TAP_W];
   assign done     = (state_ff == ST_RUN) && tap_ff[TAP_W] && !v1_ff && !v2_ff && !v3_ff;

   assign diff     = {hi_rd_ff[17], hi_rd_ff} - {lo_rd_ff[17], lo_rd_ff};
   assign wsig     = $signed({1'b0, pos_ff[23-PHASE_W:0], PHASE_W'(0)});
   assign blend    = (44'(lo_d_ff) <<< 24) + prod_ff + 44'sd8388608;
   assign coef     = blend[41:24];

   assign pos_next  = pos_ff + 40'(step_ff);
   assign nb        = pos_next[39:24];
   assign cand      = nb - 16'(HALF - 1);
   assign cand_diff = cand - oldest_ff;

   always_comb begin
      state_in  = state_ff;
      pos_in    = pos_ff;
      fw_in     = fw_ff;
      oldest_in = oldest_ff;
      cnt_in    = cnt_ff;
      have_in   = have_ff;
      tap_in    = tap_ff;
      oval_in   = oval_ff && !out_ready;
      olast_in  = olast_ff;
      och0_in   = och0_ff;
      och1_in   = och1_ff;
      v1_in     = issue;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_pop) begin
               if (ring_we) begin
                  fw_in = fw_ff + 1'b1;
               end
               if (q_item.action == ACT_SAMPLE || q_item.action == ACT_SILENCE) begin
                  state_in = ST_CHECK;
                  cnt_in   = '0;
                  have_in  = 1'b0;
               end
            end
         end
         ST_CHECK: begin
            if (!have_ff || out_free) begin
               if (have_ff) begin
                  oval_in  = 1'b1;
                  olast_in = !go;
                  och0_in  = res0_ff;
                  och1_in  = res1_ff;
                  have_in  = 1'b0;
               end
               if (go) begin
                  state_in = ST_RUN;
                  tap_in   = '0;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_RUN: begin
            if (issue) begin
               tap_in = tap_ff + 1'b1;
            end
            if (done) begin
               pos_in   = pos_next;
               cnt_in   = cnt_ff + 1'b1;
               have_in  = 1'b1;
               state_in = ST_CHECK;
               if (cand_diff != '0 && !cand_diff[15]) begin
                  oldest_in = cand;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // per-channel accumulators
   always_comb begin
      acc1_in = acc1_ff;
      if (state_ff == ST_CHECK && go && (!have_ff || out_free)) begin
         acc1_in = '0;
      end else if (v3_ff) begin
         acc1_in = acc1_ff + 48'(m1_ff);
      end
   end

   always_comb begin
      acc0_in = acc0_ff;
      if (state_ff == ST_CHECK && go && (!have_ff || out_free)) begin
         acc0_in = '0;
      end else if (v3_ff) begin
         acc0_in = acc0_ff + 48'(m0_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[fw_ff[RING_W-1:0]] <= (q_item.action == ACT_SAMPLE)
            ? {q_item.sample_ch1, q_item.sample_ch0} : 48'd0;
      end
      ring_rd_ff     <= ring_mem[slot];
      ring_rd_vld_ff <= ring_vld_ff[slot];
      if (coef_we) begin
         coef_mem[q_item.coef_index] <= q_item.coef_value;
      end
      lo_rd_ff <= coef_mem[lo_addr];
      hi_rd_ff <= coef_mem[hi_addr];

      prod_ff <= 44'(diff * wsig);
      lo_d_ff <= lo_rd_ff;
      s0_d_ff <= ring_rd_vld_ff ? $signed(ring_rd_ff[23:0]) : 24'sd0;
      s1_d_ff <= ring_rd_vld_ff ? $signed(ring_rd_ff[47:24]) : 24'sd0;
      m0_ff   <= 42'(s0_d_ff * coef);
      m1_ff   <= 42'(s1_d_ff * coef);

      acc0_ff <= acc0_in;
      acc1_ff <= acc1_in;
      res0_ff <= (done) ? round_sat(acc0_ff) : res0_ff;
      res1_ff <= (done) ? round_sat(acc1_ff) : res1_ff;
      och0_ff <= och0_in;
      och1_ff <= och1_in;
      olast_ff <= olast_in;

      if (reset) begin
         step_ff     <= 29'd16777216;
         pos_ff      <= 40'(HALF - 1) << 24;
         fw_ff       <= 16'(HALF);
         oldest_ff   <= '0;
         state_ff    <= ST_IDLE;
         cnt_ff      <= '0;
         have_ff     <= 1'b0;
         tap_ff      <= '0;
         v1_ff       <= 1'b0;
         v2_ff       <= 1'b0;
         v3_ff       <= 1'b0;
         oval_ff     <= 1'b0;
         ring_vld_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            step_ff <= csr_wr_data;
         end
         pos_ff    <= pos_in;
         fw_ff     <= fw_in;
         oldest_ff <= oldest_in;
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         have_ff   <= have_in;
         tap_ff    <= tap_in;
         v1_ff     <= v1_in;
         v2_ff     <= v1_ff;
         v3_ff     <= v2_ff;
         oval_ff   <= oval_in;
         if (ring_we) begin
            ring_vld_ff[fw_ff[RING_W-1:0]] <= 1'b1;
         end
      end
   end

   assign out_valid = oval_ff;
   assign out_ch0   = och0_ff;
   assign out_ch1   = och1_ff;
   assign out_last  = olast_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/polyphase_sinc_resampler.sv =====
// datapath: an accepted item is registered in the queue, and each output of a frame item then
// takes one tap a cycle through a coefficient blend shared by both channels and a MAC per channel
// flow: the core pops the next item from the 4-word queue in front only while idle, so it takes
// no new item before it is through with every output of the last one
// reset: synchronous, active high; sample history reads as zero until written,
// coefficients are undefined until written, step resets to 1.0
`timescale 1ns / 1ps
`default_nettype none
module polyphase_sinc_resampler import rsmp_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [28:0] csr_wr_data,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // sample_ch0, sample_ch1, coef_index, coef_value, zero pad
   input  wire logic [87:0] req_tdata,
   // action
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // out_ch0, out_ch1
   output logic [47:0]      rsp_tdata,
   output logic             rsp_tlast
);
   item_type in_item, q_item;
   logic     q_valid, q_pop;
   logic [23:0] ch0, ch1;

   assign in_item.action     = req_tuser;
   assign in_item.sample_ch0 = req_tdata[23:0];
   assign in_item.sample_ch1 = req_tdata[47:24];
   assign in_item.coef_index = req_tdata[62:48];
   assign in_item.coef_value = req_tdata[80:63];

   rsmp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_item  (in_item),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .q_pop    (q_pop)
   );

   rsmp_core u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_valid     (q_valid),
      .q_item      (q_item),
      .q_pop       (q_pop),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_ch0     (ch0),
      .out_ch1     (ch1),
      .out_last    (rsp_tlast)
   );

   assign rsp_tdata = {ch1, ch0};
endmodule
`default_nettype wire
